// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tone mixer RTL.
// No dependencies; pulled in by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property on the rising clock, ignored while the active-low reset is asserted.
`define TDM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true on a rising clock outside reset.
`define TDM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `TDM_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/core/tdm_pkg.sv =====
// Types and constants of the three-voice tone mixer.
// No dependencies; used by every module of the block.
package tdm_pkg;

  localparam int unsigned NUM_VOICES = 3;

  // Output sample rate in Hz; sets the phase step per tick
  localparam int unsigned SAMPLE_RATE = 22050;

  // Transaction kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_CONFIG  = 2'd1;
  localparam logic [1:0] KIND_DISABLE = 2'd2;
  localparam logic [1:0] KIND_MUTE    = 2'd3;

  // Waveform codes; the rest are silent
  localparam logic [2:0] SHAPE_SQUARE   = 3'd0;
  localparam logic [2:0] SHAPE_TRIANGLE = 3'd1;
  localparam logic [2:0] SHAPE_SAW      = 3'd2;
  localparam logic [2:0] SHAPE_NOISE    = 3'd3;

  // Phase step = floor(hz * 2^32 / rate), done as hz * ceil(2^65 / rate) >> 33.
  // Exact for every 16-bit hz since hz * error * 2^32 < 2^65.
  localparam int unsigned STEP_SHIFT = 65;
  localparam int unsigned STEP_MUL_W = 53;
  localparam int unsigned STEP_LO_W  = 27;
  localparam int unsigned STEP_HI_W  = STEP_MUL_W - STEP_LO_W;
  localparam int unsigned STEP_SUM_W = STEP_MUL_W + 16;
  localparam logic [STEP_MUL_W-1:0] STEP_MUL = STEP_MUL_W'(
    ((66'd1 << STEP_SHIFT) + 66'(SAMPLE_RATE) - 66'd1) / 66'(SAMPLE_RATE));
  localparam logic [STEP_LO_W-1:0] STEP_MUL_LO = STEP_MUL[STEP_LO_W-1:0];
  localparam logic [STEP_HI_W-1:0] STEP_MUL_HI = STEP_MUL[STEP_MUL_W-1:STEP_LO_W];

  // Noise seed hashing
  localparam logic [31:0] SEED_MUL = 32'd2654435761;
  localparam logic [31:0] SEED_XOR = 32'h12345678;

  // Divide by 100 for magnitudes below 2^15: (x * 41944) >> 22
  localparam logic [15:0] DIV100_MUL   = 16'd41944;
  localparam int unsigned DIV100_SHIFT = 22;

  // Mixer levels
  localparam logic [7:0] MIX_LIMIT  = 8'd255;
  localparam logic [7:0] MIX_MID    = 8'd128;
  localparam logic [7:0] MUTE_LEVEL = 8'd127;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  voice;
    logic [15:0] tone_hz;
    logic [7:0]  level;
    logic [2:0]  shape_code;
    logic        mute_on;
  } tdm_item_t;

  typedef struct packed {
    logic [7:0] pwm_level;
  } tdm_result_t;

  // Item plus the products needed by a configure
  typedef struct packed {
    tdm_item_t               item;
    logic [STEP_HI_W+15:0]   step_hi;
    logic [STEP_LO_W+15:0]   step_lo;
    logic [31:0]             seed_prod;
  } tdm_cfg_t;

  // Raw voice samples of one tick (two's complement, 0 for silent voices)
  typedef struct packed {
    logic                            muted;
    logic [NUM_VOICES-1:0][7:0]      samp;
    logic [NUM_VOICES-1:0][7:0]      level;
  } tdm_tick_t;

endpackage

// ===== rtl/core/tdm_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per transaction.
// No dependencies; the payload types come from tdm_pkg at the instance.
interface tdm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tdm_cfg_mul.sv =====
// Stage 1: phase-step partial products and noise seed product.
// Depends on tdm_pkg.
module tdm_cfg_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tdm_pkg::tdm_item_t in_item_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output tdm_pkg::tdm_cfg_t  out_cfg_o,
  input  logic               out_ready_i
);
  import tdm_pkg::*;

  logic     valid_q;
  tdm_cfg_t cfg_q;
  tdm_cfg_t cfg_d;
  logic     fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Products of the tone frequency
  always_comb begin
    cfg_d.item      = in_item_i;
    cfg_d.step_hi   = (STEP_HI_W+16)'(in_item_i.tone_hz) * (STEP_HI_W+16)'(STEP_MUL_HI);
    cfg_d.step_lo   = (STEP_LO_W+16)'(in_item_i.tone_hz) * (STEP_LO_W+16)'(STEP_MUL_LO);
    cfg_d.seed_prod = 32'(in_item_i.tone_hz) * SEED_MUL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cfg_q <= cfg_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_cfg_o   = cfg_q;

endmodule

// ===== rtl/core/tdm_voice_bank.sv =====
// Stage 2: voice state (phase, step, level, shape, noise LFSR, on, mute),
// configure/disable/mute handling and raw waveform samples. Depends on tdm_pkg.
module tdm_voice_bank (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tdm_pkg::tdm_cfg_t  in_cfg_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output tdm_pkg::tdm_tick_t out_tick_o,
  input  logic               out_ready_i
);
  import tdm_pkg::*;
  `include "assert_macros.svh"

  logic [NUM_VOICES-1:0][31:0] acc_q, acc_d;
  logic [NUM_VOICES-1:0][31:0] step_q, step_d;
  logic [NUM_VOICES-1:0][7:0]  level_q, level_d;
  logic [NUM_VOICES-1:0][2:0]  shape_q, shape_d;
  logic [NUM_VOICES-1:0][31:0] noise_q, noise_d;
  logic [NUM_VOICES-1:0]       on_q, on_d;
  logic                        muted_q, muted_d;

  logic                        valid_q;
  tdm_tick_t                   tick_q, tick_d;

  logic [NUM_VOICES-1:0][31:0] noise_nx;
  logic [NUM_VOICES-1:0][22:0] tri_prod;
  logic [NUM_VOICES-1:0][7:0]  tri_t;
  logic [NUM_VOICES-1:0][7:0]  samp;
  logic [STEP_SUM_W-1:0]       step_sum;
  logic [31:0]                 new_step;
  logic [31:0]                 seed;
  logic [31:0]                 new_seed;
  logic                        is_tick;
  logic                        fire;

  assign is_tick    = in_cfg_i.item.kind == KIND_TICK;
  // Only ticks occupy the sample register
  assign in_ready_o = !is_tick || !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Configure values: step from the partial products, seed from its product
  assign step_sum = {in_cfg_i.step_hi, {STEP_LO_W{1'b0}}} + STEP_SUM_W'(in_cfg_i.step_lo);
  assign new_step = step_sum[STEP_SHIFT-1:STEP_SHIFT-32];
  assign seed     = SEED_XOR ^ in_cfg_i.seed_prod;
  assign new_seed = (seed == 32'd0) ? 32'd1 : seed;

  // Waveform samples from the current state
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      noise_nx[i] = {noise_q[i][0] ^ noise_q[i][2] ^ noise_q[i][3] ^ noise_q[i][5],
                     noise_q[i][31:1]};
      // low 15 bits of phase[31:16] times 254
      tri_prod[i] = {acc_q[i][30:16], 8'b0} - {7'b0, acc_q[i][30:16], 1'b0};
      tri_t[i]    = tri_prod[i][22:15];
      case (shape_q[i])
        SHAPE_SQUARE:   samp[i] = acc_q[i][31] ? 8'h7F : 8'h81;
        SHAPE_TRIANGLE: samp[i] = acc_q[i][31] ? 8'd127 - tri_t[i] : tri_t[i] - 8'd127;
        SHAPE_SAW:      samp[i] = {~acc_q[i][31], acc_q[i][30:24]};
        SHAPE_NOISE:    samp[i] = {~noise_nx[i][31], noise_nx[i][30:24]};
        default:        samp[i] = 8'd0;
      endcase
      if (!on_q[i]) begin
        samp[i] = 8'd0;
      end
    end
  end

  // State update for the transaction leaving stage 1
  always_comb begin
    acc_d   = acc_q;
    step_d  = step_q;
    level_d = level_q;
    shape_d = shape_q;
    noise_d = noise_q;
    on_d    = on_q;
    muted_d = muted_q;
    if (fire) begin
      unique case (in_cfg_i.item.kind)
        KIND_TICK: begin
          if (!muted_q) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
              if (on_q[i]) begin
                acc_d[i] = acc_q[i] + step_q[i];
                if (shape_q[i] == SHAPE_NOISE) begin
                  noise_d[i] = noise_nx[i];
                end
              end
            end
          end
        end
        KIND_MUTE: begin
          muted_d = in_cfg_i.item.mute_on;
        end
        KIND_DISABLE: begin
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (in_cfg_i.item.voice == 2'(i)) begin
              on_d[i] = 1'b0;
            end
          end
        end
        KIND_CONFIG: begin
          for (int i = 0; i < NUM_VOICES; i++) begin
            if (in_cfg_i.item.voice == 2'(i)) begin
              if (in_cfg_i.item.tone_hz == 16'd0) begin
                on_d[i]   = 1'b0;
                step_d[i] = 32'd0;
              end else begin
                acc_d[i]   = 32'd0;
                step_d[i]  = new_step;
                level_d[i] = in_cfg_i.item.level;
                shape_d[i] = in_cfg_i.item.shape_code;
                noise_d[i] = new_seed;
                on_d[i]    = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sample register contents for a tick
  always_comb begin
    tick_d.muted = muted_q;
    tick_d.samp  = samp;
    tick_d.level = level_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        acc_q[i]   <= 32'd0;
        step_q[i]  <= 32'd0;
        level_q[i] <= 8'd0;
        shape_q[i] <= 3'd0;
        noise_q[i] <= 32'd1;
      end
      on_q    <= '0;
      muted_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      step_q  <= step_d;
      level_q <= level_d;
      shape_q <= shape_d;
      noise_q <= noise_d;
      on_q    <= on_d;
      muted_q <= muted_d;
      if (fire && is_tick) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && is_tick) begin
      tick_q <= tick_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_tick_o  = tick_q;

  // A muted tick leaves every voice untouched
  `TDM_ASSERT(a_muted_tick_holds, clk_i, rst_ni, (fire && is_tick && muted_q) |=> ($stable(acc_q) && $stable(noise_q)), "muted tick changed voice state")
  // A configure with a tone starts voice 0 at phase zero
  `TDM_ASSERT(a_config_starts_voice, clk_i, rst_ni, (fire && in_cfg_i.item.kind == KIND_CONFIG && in_cfg_i.item.tone_hz != 16'd0 && in_cfg_i.item.voice == 2'd0) |=> (on_q[0] && acc_q[0] == 32'd0), "configure did not start voice 0")

endmodule

// ===== rtl/core/tdm_mixer.sv =====
// Stages 3 to 5: level scaling, divide by 100, three-voice sum, clamp and
// PWM offset into the result register. Depends on tdm_pkg and tdm_stream_if.
module tdm_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  tdm_pkg::tdm_tick_t in_tick_i,
  output logic               in_ready_o,
  tdm_stream_if.source       out_o
);
  import tdm_pkg::*;

  // Stage 3: signed sample times level
  logic                        v3_q;
  logic                        muted3_q;
  logic [NUM_VOICES-1:0][15:0] prod_q;
  logic [NUM_VOICES-1:0][16:0] prod_c;
  // Stage 4: scaled voice contributions
  logic                        v4_q;
  logic                        muted4_q;
  logic [NUM_VOICES-1:0][9:0]  scaled_q;
  logic [NUM_VOICES-1:0][9:0]  scaled_c;
  logic [NUM_VOICES-1:0][15:0] mag;
  logic [NUM_VOICES-1:0][30:0] mq;
  logic [NUM_VOICES-1:0][8:0]  quot;
  // Result register
  logic                        ov_q;
  logic [7:0]                  pwm_q;
  logic [7:0]                  pwm_c;
  logic [11:0]                 sum_c;
  logic [11:0]                 abs_c;
  logic [7:0]                  clamp_c;
  logic [7:0]                  half_c;

  logic rdy3, rdy4, rdy5;
  logic fire3, fire4, fire5;

  assign rdy5       = !ov_q || out_o.ready;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign in_ready_o = rdy3;
  assign fire3      = in_valid_i && rdy3;
  assign fire4      = v3_q && rdy4;
  assign fire5      = v4_q && rdy5;

  // Volume multiply
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      prod_c[i] = 17'($signed(in_tick_i.samp[i]) * $signed({1'b0, in_tick_i.level[i]}));
    end
  end

  // Divide by 100 toward zero on the magnitude
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      mag[i]  = prod_q[i][15] ? 16'(16'd0 - prod_q[i]) : prod_q[i];
      mq[i]   = 31'(mag[i][14:0]) * 31'(DIV100_MUL);
      quot[i] = mq[i][DIV100_SHIFT+8:DIV100_SHIFT];
      scaled_c[i] = prod_q[i][15] ? 10'(10'd0 - {1'b0, quot[i]}) : {1'b0, quot[i]};
    end
  end

  // Sum, clamp to +-255, halve toward zero, offset to mid scale; mute level if muted
  always_comb begin
    sum_c = 12'd0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      sum_c = sum_c + {{2{scaled_q[i][9]}}, scaled_q[i]};
    end
    abs_c   = sum_c[11] ? 12'(12'd0 - sum_c) : sum_c;
    clamp_c = (abs_c > {4'd0, MIX_LIMIT}) ? MIX_LIMIT : abs_c[7:0];
    half_c  = {1'b0, clamp_c[7:1]};
    if (muted4_q) begin
      pwm_c = MUTE_LEVEL;
    end else if (sum_c[11]) begin
      pwm_c = MIX_MID - half_c;
    end else begin
      pwm_c = MIX_MID + half_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (fire3) begin
        v3_q <= 1'b1;
      end else if (fire4) begin
        v3_q <= 1'b0;
      end
      if (fire4) begin
        v4_q <= 1'b1;
      end else if (fire5) begin
        v4_q <= 1'b0;
      end
      if (fire5) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire3) begin
      muted3_q <= in_tick_i.muted;
      for (int i = 0; i < NUM_VOICES; i++) begin
        prod_q[i] <= prod_c[i][15:0];
      end
    end
    if (fire4) begin
      muted4_q <= muted3_q;
      scaled_q <= scaled_c;
    end
    if (fire5) begin
      pwm_q <= pwm_c;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.data.pwm_level = pwm_q;

endmodule

// ===== rtl/core/three_voice_dds_tone_mixer.sv =====
// Top level of the three-voice DDS tone mixer.
// Depends on tdm_pkg, tdm_stream_if, tdm_cfg_mul, tdm_voice_bank, tdm_mixer.
//
// Three DDS voices (square, triangle, saw, LFSR noise) with 32-bit phase
// accumulators, mixed into an 8-bit PWM duty value. Every transaction on in_i
// is one of: sample tick, configure voice, disable voice, set mute; only a
// tick produces a transaction on out_o. The design is a six-register pipeline
// (input, step multiply, voice state, volume multiply, divide by 100, result),
// so one transaction is taken every clock while out_o is not stalled. Voice
// state lives in the third register stage, so back-to-back configure and
// tick transactions see each other in order. Back-pressure on out_o stalls
// only the stages that are full; non-tick transactions drain past a stalled
// sample stage.
module three_voice_dds_tone_mixer (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdm_stream_if.sink   in_i,
  tdm_stream_if.source out_o
);
  import tdm_pkg::*;
  `include "assert_macros.svh"

  logic      v0_q;
  tdm_item_t item0_q;
  logic      rdy1;
  logic      v1;
  tdm_cfg_t  cfg1;
  logic      rdy2;
  logic      v2;
  tdm_tick_t tick2;
  logic      rdy3;
  logic      fire0;

  // Input register
  assign in_i.ready = !v0_q || rdy1;
  assign fire0      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (fire0) begin
      v0_q <= 1'b1;
    end else if (rdy1) begin
      v0_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire0) begin
      item0_q <= in_i.data;
    end
  end

  tdm_cfg_mul u_cfg_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v0_q),
    .in_item_i   (item0_q),
    .in_ready_o  (rdy1),
    .out_valid_o (v1),
    .out_cfg_o   (cfg1),
    .out_ready_i (rdy2)
  );

  tdm_voice_bank u_voice_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1),
    .in_cfg_i    (cfg1),
    .in_ready_o  (rdy2),
    .out_valid_o (v2),
    .out_tick_o  (tick2),
    .out_ready_i (rdy3)
  );

  tdm_mixer u_mixer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v2),
    .in_tick_i  (tick2),
    .in_ready_o (rdy3),
    .out_o      (out_o)
  );

  // Clamped and halved mix plus offset never reaches zero
  `TDM_ASSERT_NEVER(a_pwm_nonzero, clk_i, rst_ni, out_o.valid && out_o.data.pwm_level == 8'd0, "pwm level of zero")
  // The sample stage fills only from a tick leaving stage 1
  `TDM_ASSERT(a_sample_from_tick, clk_i, rst_ni, $rose(v2) |-> $past(v1 && cfg1.item.kind == KIND_TICK), "sample stage loaded without a tick")
  // A blocked input register keeps its transaction
  `TDM_ASSERT(a_input_holds, clk_i, rst_ni, (v0_q && !rdy1) |=> (v0_q && $stable(item0_q)), "input register lost a stalled transaction")

endmodule

// ===== dv/tb_three_voice_dds_tone_mixer.sv =====
`timescale 1ns / 1ps
// Testbench for the three-voice DDS tone mixer: directed table, then random traffic.
// Depends on tdm_pkg, tdm_stream_if and three_voice_dds_tone_mixer from the RTL.
module tb_three_voice_dds_tone_mixer;
  import tdm_pkg::*;

  localparam int          VOICE_CNT      = 3;
  localparam int          MAX_CYCLES     = 200000;
  localparam int          PIPE_SETTLE    = 12;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam logic [31:0] NOISE_SEED_XOR = 32'h1234_5678;
  localparam logic [31:0] NOISE_SEED_MUL = 32'd2654435761;
  localparam logic [7:0]  MUTED_DUTY     = 8'd127;
  localparam logic [7:0]  IDLE_DUTY      = 8'd128;
  localparam int          DUTY_MID       = 128;
  localparam int          MIX_CLAMP      = 255;
  localparam int          TRI_HALF       = 32768;
  localparam int          N_DIR          = 25;

  // One row of the directed table; pwm is used only when typed is set
  typedef struct packed {
    tdm_item_t  item;
    logic       typed;
    logic [7:0] pwm;
  } dir_row_t;

  logic clk;
  logic rst_n;

  tdm_stream_if #(.T(tdm_item_t))   in_if ();
  tdm_stream_if #(.T(tdm_result_t)) out_if ();

  three_voice_dds_tone_mixer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted voice state
  logic [31:0] ph_acc     [VOICE_CNT];
  logic [31:0] ph_step    [VOICE_CNT];
  logic [7:0]  voice_vol  [VOICE_CNT];
  logic [2:0]  voice_wave [VOICE_CNT];
  logic [31:0] noise_lfsr [VOICE_CNT];
  logic        voice_en   [VOICE_CNT];
  logic        eng_muted;

  logic [7:0] duty_expect_q [$];
  dir_row_t   dir_rows [N_DIR];

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int hold_ack;
  int hold_left;
  int cycle_cnt;
  int n_fail;
  int n_checked;
  int n_items;
  int n_ticks;
  int n_setups;
  int n_mutes;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Known values on every input from time zero
  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    rx_idle_pct  = 0;
    hold_req     = 0;
    hold_ack     = 0;
    hold_left    = 0;
    cycle_cnt    = 0;
    n_fail       = 0;
    n_checked    = 0;
    for (int v = 0; v < VOICE_CNT; v++) begin
      ph_acc[v]     = '0;
      ph_step[v]    = '0;
      voice_vol[v]  = '0;
      voice_wave[v] = '0;
      noise_lfsr[v] = 32'd1;
      voice_en[v]   = 1'b0;
    end
    eng_muted = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Scaled sample of one voice; advances its phase and noise state
  function automatic int voice_sample(input int v);
    int          s;
    logic [31:0] x;
    logic [15:0] p;
    if (!voice_en[v]) return 0;
    case (voice_wave[v])
      SHAPE_SQUARE:   s = ph_acc[v][31] ? 127 : -127;
      SHAPE_TRIANGLE: begin
        p = ph_acc[v][31:16];
        if (int'(p) < TRI_HALF) s = -127 + (int'(p) * 254) / TRI_HALF;
        else s = 127 - ((int'(p) - TRI_HALF) * 254) / TRI_HALF;
      end
      SHAPE_SAW:      s = int'(ph_acc[v][31:24]) - 128;
      SHAPE_NOISE: begin
        x = noise_lfsr[v];
        x = {x[0] ^ x[2] ^ x[3] ^ x[5], x[31:1]};
        noise_lfsr[v] = x;
        s = int'(x[31:24]) - 128;
      end
      default:        s = 0;
    endcase
    ph_acc[v] = ph_acc[v] + ph_step[v];
    return (s * int'(voice_vol[v])) / 100;
  endfunction

  // Updates the predicted state for one transaction and gives its duty value, if any
  task automatic predict_duty(input tdm_item_t it, output bit has_duty,
                              output logic [7:0] duty);
    int          mix;
    logic [63:0] num;
    logic [31:0] seed;
    has_duty = 1'b0;
    duty     = '0;
    case (it.kind)
      KIND_TICK: begin
        has_duty = 1'b1;
        if (eng_muted) begin
          duty = MUTED_DUTY;
        end else begin
          mix = 0;
          for (int v = 0; v < VOICE_CNT; v++) mix += voice_sample(v);
          if (mix > MIX_CLAMP) mix = MIX_CLAMP;
          if (mix < -MIX_CLAMP) mix = -MIX_CLAMP;
          duty = 8'(DUTY_MID + mix / 2);
        end
      end
      KIND_MUTE: eng_muted = it.mute_on;
      KIND_DISABLE: begin
        if (it.voice < VOICE_CNT) voice_en[it.voice] = 1'b0;
      end
      KIND_CONFIG: begin
        if (it.voice < VOICE_CNT) begin
          if (it.tone_hz == 16'd0) begin
            // zero tone: voice off, step cleared, the rest kept
            voice_en[it.voice] = 1'b0;
            ph_step[it.voice]  = '0;
          end else begin
            num  = {16'd0, it.tone_hz, 32'd0};
            seed = NOISE_SEED_XOR ^ (32'(it.tone_hz) * NOISE_SEED_MUL);
            ph_acc[it.voice]     = '0;
            ph_step[it.voice]    = 32'(num / 64'(SAMPLE_RATE));
            voice_vol[it.voice]  = it.level;
            voice_wave[it.voice] = it.shape_code;
            noise_lfsr[it.voice] = (seed == 32'd0) ? 32'd1 : seed;
            voice_en[it.voice]   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Output side: check each result transaction, then pick the next ready
  always @(posedge clk) begin : rx_side
    logic [7:0] duty_want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (duty_expect_q.size() == 0) begin
        $error("pwm_level: unexpected result %0d with nothing pending",
               out_if.data.pwm_level);
        n_fail++;
      end else begin
        duty_want = duty_expect_q.pop_front();
        n_checked++;
        if (out_if.data.pwm_level !== duty_want) begin
          $error("pwm_level mismatch: expected %0d, actual %0d",
                 duty_want, out_if.data.pwm_level);
          n_fail++;
        end
      end
    end
    // long hold-off on request, counted here
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic tdm_item_t mk(input logic [1:0] kind, input logic [1:0] voice,
                                   input logic [15:0] hz, input logic [7:0] lvl,
                                   input logic [2:0] wave, input logic mute);
    tdm_item_t it;
    it.kind       = kind;
    it.voice      = voice;
    it.tone_hz    = hz;
    it.level      = lvl;
    it.shape_code = wave;
    it.mute_on    = mute;
    return it;
  endfunction

  // Mostly ticks with voice setups and disables sprinkled in; some off-range voices and mutes
  function automatic tdm_item_t rand_item();
    tdm_item_t   it;
    int unsigned r;
    it = tdm_item_t'($urandom);
    r  = $urandom_range(99);
    if (r < 68) begin
      it.kind = KIND_TICK;
    end else if (r < 93) begin
      it.kind  = (r < 86) ? KIND_CONFIG : KIND_DISABLE;
      it.voice = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      case ($urandom_range(9))
        0:       it.tone_hz = 16'd0;
        1, 2:    it.tone_hz = 16'($urandom_range(2000, 1));
        default: ;
      endcase
    end else begin
      it.kind    = KIND_MUTE;
      it.mute_on = ($urandom_range(2) == 0);
    end
    return it;
  endfunction

  // Offer one transaction, wait for acceptance, record the expectation
  task automatic offer_item(input tdm_item_t it, input logic typed,
                            input logic [7:0] typed_pwm);
    bit         has_duty;
    logic [7:0] duty;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_duty(it, has_duty, duty);
    if (has_duty) duty_expect_q.push_back(typed ? typed_pwm : duty);
    n_items++;
    case (it.kind)
      KIND_TICK:   n_ticks++;
      KIND_CONFIG: n_setups++;
      KIND_MUTE:   n_mutes++;
      default: ;
    endcase
  endtask

  // Sender pause until every expected result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (duty_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    tdm_item_t it;
    n_items  = 0;
    n_ticks  = 0;
    n_setups = 0;
    n_mutes  = 0;
    dir_rows = '{
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b1, IDLE_DUTY},
      '{mk(KIND_CONFIG,  2'd0, 16'd440,   8'd100, SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_CONFIG,  2'd1, 16'hFFFF,  8'd255, SHAPE_TRIANGLE, 1'b0), 1'b0, 8'd0},
      '{mk(KIND_CONFIG,  2'd2, 16'd1,     8'd0,   SHAPE_SAW,      1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd1, 16'd7,     8'd9,   3'd5,           1'b1), 1'b0, 8'd0},
      '{mk(KIND_CONFIG,  2'd2, 16'hFFFF,  8'd255, SHAPE_NOISE,    1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_CONFIG,  2'd0, 16'd1000,  8'd255, 3'd7,           1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      // voice index 3 is ignored by setup and disable
      '{mk(KIND_CONFIG,  2'd3, 16'd500,   8'd200, SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_DISABLE, 2'd3, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_DISABLE, 2'd1, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      // zero tone turns the voice off and clears its step but keeps its other settings
      '{mk(KIND_CONFIG,  2'd2, 16'd0,     8'd255, 3'd7,           1'b1), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_MUTE,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b1), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b1, MUTED_DUTY},
      '{mk(KIND_MUTE,    2'd3, 16'hFFFF,  8'd255, 3'd7,           1'b0), 1'b0, 8'd0},
      // half the sample rate: square flips each tick and clips both ways
      '{mk(KIND_CONFIG,  2'd0, 16'd11025, 8'd255, SHAPE_SQUARE,   1'b0), 1'b0, 8'd0},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b1, 8'd1},
      '{mk(KIND_TICK,    2'd0, 16'd0,     8'd0,   SHAPE_SQUARE,   1'b0), 1'b1, 8'd255},
      '{mk(KIND_TICK,    2'd3, 16'hFFFF,  8'd255, 3'd7,           1'b1), 1'b0, 8'd0}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 24;
    rx_idle_pct <= 57;
    foreach (dir_rows[i]) offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].pwm);
    drain();
    repeat (700) offer_item(rand_item(), 1'b0, 8'd0);
    drain();

    tx_idle_pct = 57;
    rx_idle_pct <= 24;
    repeat (700) offer_item(rand_item(), 1'b0, 8'd0);
    drain();

    // no idling; one long output hold-off while ticks keep coming
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (300) offer_item(rand_item(), 1'b0, 8'd0);
    hold_req <= hold_req + 1;
    repeat (40) begin
      it      = rand_item();
      it.kind = KIND_TICK;
      offer_item(it, 1'b0, 8'd0);
    end
    repeat (260) offer_item(rand_item(), 1'b0, 8'd0);
    drain();

    $display("Run: %0d transactions (%0d ticks, %0d voice setups, %0d mute changes),",
             n_items, n_ticks, n_setups, n_mutes);
    $display("  %0d duty values checked under mixed stalls and one %0d-cycle hold-off.",
             n_checked, RX_HOLD_CYCLES);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
